[rtl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the min priority queue with decrease-key.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VERTEX_BITS    = 6;
    localparam int FIELD_KEY_BITS = 16;
    localparam int STATUS_BITS    = 3;
    localparam int TOTAL_BITS     = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_APPENDED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_LOWERED   = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_UNCHANGED = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_POPPED    = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_POP_EMPTY = 3'd4;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd5;

    typedef struct packed {
        logic                      kind;
        logic [VERTEX_BITS-1:0]    vertex_id;
        logic [FIELD_KEY_BITS-1:0] new_key;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0]    status;
        logic [VERTEX_BITS-1:0]    popped_vertex;
        logic [FIELD_KEY_BITS-1:0] popped_key;
        logic [VERTEX_BITS-1:0]    top_vertex;
        logic [FIELD_KEY_BITS-1:0] top_key;
        logic [TOTAL_BITS-1:0]     entry_total;
        logic                      is_empty;
    } t_out_item;

endpackage

[rtl/min_priority_queue_decrease_key_core.sv]
// entries held: at most CAPACITY; a new item is stalled until the last result is
// loaded into the output register; the slot memory (one read and one write port) is
// walked once for the vertex search or the pop shift, then once more for the slot 0
// settle pass; an empty pop skips both, a full queue the settle, a slot 0 hit the search
// reset: synchronous active low; the queue comes up empty, slot memory is not cleared
// ----------------------------------------------------------------------------
// min_priority_queue_decrease_key_core
// Ordered list of (vertex, key) entries with the minimum kept in slot 0.
// Slot 0 lives in registers, the other slots in a synchronous memory.
// ----------------------------------------------------------------------------
module min_priority_queue_decrease_key_core #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = mpq_pkg::KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mpq_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mpq_pkg::t_out_item o_out_data
);
    import mpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = VERTEX_BITS + KEY_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_START  = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_SETTLE = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [EW-1:0] mem [CAPACITY];

    logic [2:0]             r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_rd_vld, n_rd_vld;
    logic [AW-1:0]          r_rd_addr, n_rd_addr;
    logic [EW-1:0]          r_rd_data;
    logic [VERTEX_BITS-1:0] r_top_v, n_top_v;
    logic [KEY_BITS-1:0]    r_top_k, n_top_k;
    logic                   r_kind, n_kind;
    logic [VERTEX_BITS-1:0] r_vid, n_vid;
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [STATUS_BITS-1:0] r_status, n_status;
    logic [VERTEX_BITS-1:0] r_pop_v, n_pop_v;
    logic [KEY_BITS-1:0]    r_pop_k, n_pop_k;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out, n_out;

    logic                   rd_en;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic [VERTEX_BITS-1:0] rd_v;
    logic [KEY_BITS-1:0]    rd_k;
    logic                   w_issue;
    logic [KEY_BITS+FIELD_KEY_BITS-1:0] w_in_key_wide;
    logic [KEY_BITS+FIELD_KEY_BITS-1:0] w_top_key_wide;
    logic [KEY_BITS+FIELD_KEY_BITS-1:0] w_pop_key_wide;
    logic [CW+TOTAL_BITS-1:0]           w_count_wide;

    assign rd_v    = r_rd_data[EW-1:KEY_BITS];
    assign rd_k    = r_rd_data[KEY_BITS-1:0];
    assign w_issue = (r_idx < r_count);

    // key field width against stored key width, either way round
    assign w_in_key_wide  = {{KEY_BITS{1'b0}}, i_in_data.new_key};
    assign w_top_key_wide = {{FIELD_KEY_BITS{1'b0}}, r_top_k};
    assign w_pop_key_wide = {{FIELD_KEY_BITS{1'b0}}, r_pop_k};
    assign w_count_wide   = {{TOTAL_BITS{1'b0}}, r_count};

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_rd_addr   = r_rd_addr;
        n_top_v     = r_top_v;
        n_top_k     = r_top_k;
        n_kind      = r_kind;
        n_vid       = r_vid;
        n_key       = r_key;
        n_status    = r_status;
        n_pop_v     = r_pop_v;
        n_pop_k     = r_pop_k;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = r_rd_addr;
        wr_data     = r_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_kind  = i_in_data.kind;
                    n_vid   = i_in_data.vertex_id;
                    n_key   = w_in_key_wide[KEY_BITS-1:0];
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_idx   = CW'(1);
                n_pop_v = '0;
                n_pop_k = '0;
                if (r_kind == KIND_POP) begin
                    if (r_count == '0) begin
                        n_status = STATUS_POP_EMPTY;
                        n_state  = ST_DONE;
                    end else begin
                        n_status = STATUS_POPPED;
                        n_pop_v  = r_top_v;
                        n_pop_k  = r_top_k;
                        n_state  = ST_SHIFT;
                    end
                end else if (r_count != '0 && r_top_v == r_vid) begin
                    if (r_key < r_top_k) begin
                        n_top_k  = r_key;
                        n_status = STATUS_LOWERED;
                    end else begin
                        n_status = STATUS_UNCHANGED;
                    end
                    n_state = ST_SETTLE;
                end else begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_rd_vld && rd_v == r_vid) begin
                    // match: no further read so nothing spills into the settle pass
                    if (r_key < rd_k) begin
                        wr_en    = 1'b1;
                        wr_data  = {r_vid, r_key};
                        n_status = STATUS_LOWERED;
                    end else begin
                        n_status = STATUS_UNCHANGED;
                    end
                    n_idx   = CW'(1);
                    n_state = ST_SETTLE;
                end else if (w_issue) begin
                    rd_en     = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                end else if (!r_rd_vld) begin
                    if (r_count >= CW'(CAPACITY)) begin
                        n_status = STATUS_FULL;
                        n_state  = ST_DONE;
                    end else begin
                        if (r_count == '0) begin
                            n_top_v = r_vid;
                            n_top_k = r_key;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_data = {r_vid, r_key};
                        end
                        n_count  = r_count + CW'(1);
                        n_status = STATUS_APPENDED;
                        n_idx    = CW'(1);
                        n_state  = ST_SETTLE;
                    end
                end
            end
            ST_SHIFT: begin
                if (r_rd_vld) begin
                    if (r_rd_addr == AW'(1)) begin
                        n_top_v = rd_v;
                        n_top_k = rd_k;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = r_rd_addr - AW'(1);
                    end
                end
                if (w_issue) begin
                    rd_en     = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                end else if (!r_rd_vld) begin
                    n_count = r_count - CW'(1);
                    n_idx   = CW'(1);
                    n_state = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                // swap any strictly smaller entry into slot 0
                if (r_rd_vld && rd_k < r_top_k) begin
                    wr_en   = 1'b1;
                    wr_data = {r_top_v, r_top_k};
                    n_top_v = rd_v;
                    n_top_k = rd_k;
                end
                if (w_issue) begin
                    rd_en     = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_addr = r_idx[AW-1:0];
                    n_idx     = r_idx + CW'(1);
                end else if (!r_rd_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status        = r_status;
                    n_out.popped_vertex = r_pop_v;
                    n_out.popped_key    = w_pop_key_wide[FIELD_KEY_BITS-1:0];
                    if (r_count == '0) begin
                        n_out.top_vertex = '0;
                        n_out.top_key    = '0;
                    end else begin
                        n_out.top_vertex = r_top_v;
                        n_out.top_key    = w_top_key_wide[FIELD_KEY_BITS-1:0];
                    end
                    n_out.entry_total = w_count_wide[TOTAL_BITS-1:0];
                    n_out.is_empty    = (r_count == '0);
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_rd_addr <= n_rd_addr;
        r_top_v   <= n_top_v;
        r_top_k   <= n_top_k;
        r_kind    <= n_kind;
        r_vid     <= n_vid;
        r_key     <= n_key;
        r_status  <= n_status;
        r_pop_v   <= n_pop_v;
        r_pop_k   <= n_pop_k;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

endmodule
